FILE: rtl/hsl2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB package
// Fixed-point widths, constants and transaction types for the converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Fixed-point scaling: 2^FRAC_BITS means 1.0
    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;

    // Port field widths
    localparam int HUE_W = 12;
    localparam int SL_W  = 13;
    localparam int OUT_W = 16;

    // Internal widths
    localparam int FX_W  = FRAC_BITS + 1;        // clamped s, l in [0, ONE]
    localparam int T_W   = FRAC_BITS + 2;        // hue position in thirds, < 3*ONE
    localparam int M_W   = 2 * FRAC_BITS + 1;    // m1, d scaled by ONE^2
    localparam int F_W   = FRAC_BITS + 1;        // ramp factor in [0, ONE]
    localparam int P_W   = M_W + F_W;            // product width
    localparam int V_W   = 3 * FRAC_BITS + 1;    // channel scaled by ONE^3
    localparam int SH    = 3 * FRAC_BITS - OUT_W; // bits dropped when scaling out
    localparam int Q_W   = V_W - SH;             // scaled channel before saturation

    localparam int NUM_CH = 3;                   // red, green, blue

    typedef struct packed {
        logic [HUE_W-1:0] hue_in;
        logic [SL_W-1:0]  saturation_in;
        logic [SL_W-1:0]  lightness_in;
    } t_hsl;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } t_rgb;

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// An accepted start reaches o_valid via r_s1_vld to r_s4_vld and r_out_vld.
// Throughput: one transaction per cycle; the five register stages each take one
// item, and the d*f multipliers of stage 3 set the longest path.
// busy stays low: results stream out on o_valid and are never held off.
// Reset (synchronous, active low) clears the stage valid bits; data is not cleared.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Five-stage pipeline converting hue/saturation/lightness to 16-bit RGB.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  hsl2rgb_pkg::t_hsl  i_hsl,
    output logic               o_valid,
    output hsl2rgb_pkg::t_rgb  o_rgb
);
    import hsl2rgb_pkg::*;

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic                  r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;
    logic                  n_s1_vld;

    logic [FX_W-1:0]       r_s1_l, r_s1_s;
    logic [M_W-1:0]        r_s1_ls;
    logic                  r_s1_low;
    logic [T_W-1:0]        r_s1_t [NUM_CH];

    logic [M_W-1:0]        r_s2_m1, r_s2_d;
    logic [F_W-1:0]        r_s2_f [NUM_CH];

    logic [M_W-1:0]        r_s3_m1;
    logic [P_W-1:0]        r_s3_p [NUM_CH];

    logic [V_W-1:0]        r_s4_v [NUM_CH];

    logic [OUT_W-1:0]      r_out_ch [NUM_CH];

    // Stage 1 next values
    logic [FX_W-1:0]       n_s1_l, n_s1_s;
    logic [M_W-1:0]        n_s1_ls;
    logic                  n_s1_low;
    logic [T_W-1:0]        n_s1_t [NUM_CH];
    logic [FRAC_BITS-1:0]  hue_w;
    logic [T_W-1:0]        th;
    logic [T_W:0]          th_r_sum, th_b_sum;
    logic [2*FX_W-1:0]     ls_full;

    // Stage 2 next values
    logic [M_W-1:0]        n_s2_m1, n_s2_d;
    logic [F_W-1:0]        n_s2_f [NUM_CH];
    logic [M_W-1:0]        l_sh, s_sh;
    logic [M_W:0]          m1_hi;
    logic [M_W-1:0]        sl_diff;

    // Stage 3 / 4 / 5 next values
    logic [P_W-1:0]        n_s3_p [NUM_CH];
    logic [V_W-1:0]        n_s4_v [NUM_CH];
    logic [OUT_W-1:0]      n_out_ch [NUM_CH];

    // Never stalls
    assign busy     = 1'b0;
    assign n_s1_vld = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: clamp, l*s, hue positions in thirds of a unit
    // ------------------------------------------------------------------
    always_comb begin
        n_s1_s   = (i_hsl.saturation_in > SL_W'(ONE)) ? FX_W'(ONE)
                                                      : i_hsl.saturation_in[FX_W-1:0];
        n_s1_l   = (i_hsl.lightness_in > SL_W'(ONE)) ? FX_W'(ONE)
                                                     : i_hsl.lightness_in[FX_W-1:0];
        n_s1_low = ({n_s1_l, 1'b0} <= (FX_W+1)'(ONE));
        ls_full  = n_s1_l * n_s1_s;
        n_s1_ls  = ls_full[M_W-1:0];

        // hue wraps modulo 1.0
        hue_w    = i_hsl.hue_in[FRAC_BITS-1:0];
        th       = {2'b00, hue_w} + {1'b0, hue_w, 1'b0};
        th_r_sum = {1'b0, th} + (T_W+1)'(ONE);
        th_b_sum = {1'b0, th} + (T_W+1)'(2 * ONE);
        if (th_r_sum >= (T_W+1)'(3 * ONE)) begin
            th_r_sum = th_r_sum - (T_W+1)'(3 * ONE);
        end
        if (th_b_sum >= (T_W+1)'(3 * ONE)) begin
            th_b_sum = th_b_sum - (T_W+1)'(3 * ONE);
        end
        n_s1_t[0] = th_r_sum[T_W-1:0];
        n_s1_t[1] = th;
        n_s1_t[2] = th_b_sum[T_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: m1, d = m2 - m1, and ramp factor per channel
    // Channel = (m1*ONE + d*f), f in [0, ONE]
    // ------------------------------------------------------------------
    always_comb begin
        l_sh    = {r_s1_l, {FRAC_BITS{1'b0}}};
        s_sh    = {r_s1_s, {FRAC_BITS{1'b0}}};
        sl_diff = s_sh - r_s1_ls;
        m1_hi   = {1'b0, l_sh} - {1'b0, s_sh} + {1'b0, r_s1_ls};
        if (r_s1_low) begin
            n_s2_m1 = l_sh - r_s1_ls;
            n_s2_d  = {r_s1_ls[M_W-2:0], 1'b0};
        end else begin
            n_s2_m1 = m1_hi[M_W-1:0];
            n_s2_d  = {sl_diff[M_W-2:0], 1'b0};
        end
    end

    // Piecewise-linear ramp: rise, hold at m2, fall, hold at m1
    always_comb begin
        logic [T_W:0] two_t;
        logic [T_W-1:0] fall_d;
        for (int c = 0; c < NUM_CH; c++) begin
            two_t  = {r_s1_t[c], 1'b0};
            fall_d = T_W'(2 * ONE) - r_s1_t[c];
            if (two_t < (T_W+1)'(ONE)) begin
                n_s2_f[c] = two_t[F_W-1:0];
            end else if (two_t < (T_W+1)'(3 * ONE)) begin
                n_s2_f[c] = F_W'(ONE);
            end else if (r_s1_t[c] < T_W'(2 * ONE)) begin
                n_s2_f[c] = {fall_d[FRAC_BITS-1:0], 1'b0};
            end else begin
                n_s2_f[c] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: d * f per channel
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_s3_p[c] = r_s2_d * r_s2_f[c];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add m1 * ONE
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_s4_v[c] = {r_s3_m1, {FRAC_BITS{1'b0}}} + r_s3_p[c][V_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale to 16 bits, round half to even, saturate
    // ------------------------------------------------------------------
    always_comb begin
        logic [Q_W-1:0] q;
        logic [SH-1:0]  rem;
        logic           rnd_up;
        logic [Q_W:0]   q_rnd;
        for (int c = 0; c < NUM_CH; c++) begin
            q      = r_s4_v[c][V_W-1:SH];
            rem    = r_s4_v[c][SH-1:0];
            rnd_up = rem[SH-1] && ((|rem[SH-2:0]) || q[0]);
            q_rnd  = {1'b0, q} + (Q_W+1)'(rnd_up);
            if (|q_rnd[Q_W:OUT_W]) begin
                n_out_ch[c] = '1;
            end else begin
                n_out_ch[c] = q_rnd[OUT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // ------------------------------------------------------------------
    // Data pipeline (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s1_l   <= n_s1_l;
        r_s1_s   <= n_s1_s;
        r_s1_ls  <= n_s1_ls;
        r_s1_low <= n_s1_low;
        r_s2_m1  <= n_s2_m1;
        r_s2_d   <= n_s2_d;
        r_s3_m1  <= r_s2_m1;
        for (int c = 0; c < NUM_CH; c++) begin
            r_s1_t[c]   <= n_s1_t[c];
            r_s2_f[c]   <= n_s2_f[c];
            r_s3_p[c]   <= n_s3_p[c];
            r_s4_v[c]   <= n_s4_v[c];
            r_out_ch[c] <= n_out_ch[c];
        end
    end

    assign o_valid         = r_out_vld;
    assign o_rgb.red_out   = r_out_ch[0];
    assign o_rgb.green_out = r_out_ch[1];
    assign o_rgb.blue_out  = r_out_ch[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted transaction enters stage 1
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s1_vld)
        else $error("accepted transaction did not enter stage 1");

    // a result only follows a valid stage 4
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_s4_vld))
        else $error("result strobe without a valid stage 4");

    // m2 = m1 + d never exceeds 1.0
    a_m2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (({1'b0, r_s2_m1} + {1'b0, r_s2_d}) <= (M_W+1)'(ONE * ONE)))
        else $error("m2 above full scale");

    // ramp factor never exceeds 1.0
    a_f_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> ((r_s2_f[0] <= F_W'(ONE)) && (r_s2_f[1] <= F_W'(ONE))
                      && (r_s2_f[2] <= F_W'(ONE))))
        else $error("ramp factor above full scale");

    // green channel value stays within 1.0 before scaling
    a_v_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_v[1] <= (V_W'(1) << (3 * FRAC_BITS))))
        else $error("green channel above full scale");

endmodule
